[hdl/sgs_pkg.sv]
// ---------------------------------------------------------------------------
// sgs_pkg
// Shared widths, controller states and command/status bundles for the
// sorted group sum table.
// ---------------------------------------------------------------------------
`default_nettype none

package sgs_pkg;

    localparam int KEY_W = 31;
    localparam int AMT_W = 32;
    localparam int TOT_W = 47;

    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD,
        ST_DUMP
    } sgs_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // latch the incoming request
        logic compare;    // register per-entry compare flags
        logic update;     // apply insert / accumulate
        logic dump_load;  // move head entry to output register, shift table down
    } sgs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic eos;         // latched request carries end of set
        logic last_entry;  // exactly one entry left in the table
        logic out_free;    // output register can take a new result
    } sgs_status_t;

    // saturating add of a non-negative amount to a running total
    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] total,
                                                 input logic [AMT_W-2:0] amt);
        logic [TOT_W:0] sum;
        sum = {1'b0, total} + (TOT_W+1)'(amt);
        return sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/sgs_in_if.sv]
// ---------------------------------------------------------------------------
// sgs_in_if
// Input record channel: valid/ready handshake with key, amount, end mark.
// ---------------------------------------------------------------------------
`default_nettype none

interface sgs_in_if
    import sgs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] group_key;
    logic [AMT_W-1:0] amount;
    logic             end_of_set;

    modport source (output valid, output group_key, output amount, output end_of_set,
                    input ready);
    modport sink   (input valid, input group_key, input amount, input end_of_set,
                    output ready);
endinterface

`default_nettype wire

[hdl/sgs_out_if.sv]
// ---------------------------------------------------------------------------
// sgs_out_if
// Result channel: valid/ready handshake with one table entry per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface sgs_out_if
    import sgs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] out_key;
    logic [TOT_W-1:0] out_total;
    logic             out_last;
    logic             overflowed;

    modport source (output valid, output out_key, output out_total, output out_last,
                    output overflowed, input ready);
    modport sink   (input valid, input out_key, input out_total, input out_last,
                    input overflowed, output ready);
endinterface

`default_nettype wire

[hdl/sgs_ctrl.sv]
// ---------------------------------------------------------------------------
// sgs_ctrl
// Controller: sequences accept, compare, update and dump of the table.
// ---------------------------------------------------------------------------
`default_nettype none

module sgs_ctrl
    import sgs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire sgs_status_t status,
    output sgs_cmd_t         cmd
);

    sgs_state_t state_reg;
    sgs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD:
            begin
                // next request may enter here: its compare sees the updated table
                cmd.update = 1'b1;
                in_ready   = !status.eos;
                cmd.accept = in_valid && !status.eos;
                if (status.eos)
                begin
                    state_next = ST_DUMP;
                end
                else if (in_valid)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                cmd.dump_load = status.out_free;
                if (status.out_free && status.last_entry)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/sgs_datapath.sv]
// ---------------------------------------------------------------------------
// sgs_datapath
// Sorted register array with per-entry compare, ordered insert by shift,
// saturating accumulate, and head-of-table dump into an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module sgs_datapath
    import sgs_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sgs_cmd_t         cmd,
    output sgs_status_t           status,
    input  wire logic [KEY_W-1:0] group_key,
    input  wire logic [AMT_W-1:0] amount,
    input  wire logic             end_of_set,
    sgs_out_if.source             out_ch
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // table storage, no reset: only entries below the count are used
    logic [KEY_W-1:0] key_reg  [CAPACITY];
    logic [TOT_W-1:0] tot_reg  [CAPACITY];
    logic [KEY_W-1:0] key_next [CAPACITY];
    logic [TOT_W-1:0] tot_next [CAPACITY];
    logic [KEY_W-1:0] prev_key [CAPACITY];
    logic [TOT_W-1:0] prev_tot [CAPACITY];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic [KEY_W-1:0] in_key_reg;
    logic [AMT_W-1:0] in_amt_reg;
    logic             eos_reg;

    logic [CAPACITY-1:0] le_reg;
    logic [CAPACITY-1:0] eq_reg;
    logic [CAPACITY-1:0] le_next;
    logic [CAPACITY-1:0] eq_next;
    logic [CAPACITY-1:0] prev_le;

    logic             out_valid_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic [TOT_W-1:0] out_tot_reg;
    logic             out_last_reg;
    logic             out_ovf_reg;

    logic             hit;
    logic             full;
    logic             amt_pos;
    logic [AMT_W-2:0] amt_mag;

    assign hit     = |eq_reg;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign amt_pos = !in_amt_reg[AMT_W-1];
    assign amt_mag = in_amt_reg[AMT_W-2:0];
    assign prev_le = {le_reg[CAPACITY-2:0], 1'b1};

    // compare stage: a <= and an == comparator per entry
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            le_next[i] = (CNT_W'(i) < count_reg) && (key_reg[i] <= in_key_reg);
            eq_next[i] = (CNT_W'(i) < count_reg) && (key_reg[i] == in_key_reg);
        end
    end

    always_comb
    begin
        prev_key[0] = '0;
        prev_tot[0] = '0;
        for (int i = 1; i < CAPACITY; i++)
        begin
            prev_key[i] = key_reg[i-1];
            prev_tot[i] = tot_reg[i-1];
        end
    end

    // per-entry next value
    always_comb
    begin
        key_next   = key_reg;
        tot_next   = tot_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.update)
        begin
            if (hit)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (eq_reg[i] && amt_pos)
                    begin
                        tot_next[i] = sat_add(tot_reg[i], amt_mag);
                    end
                end
            end
            else if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if ((CNT_W'(i) <= count_reg) && !le_reg[i])
                    begin
                        if (prev_le[i])
                        begin
                            // insertion point
                            key_next[i] = in_key_reg;
                            tot_next[i] = amt_pos ? TOT_W'(amt_mag) : '0;
                        end
                        else
                        begin
                            key_next[i] = prev_key[i];
                            tot_next[i] = prev_tot[i];
                        end
                    end
                end
            end
        end
        else if (cmd.dump_load)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                key_next[i] = key_reg[i+1];
                tot_next[i] = tot_reg[i+1];
            end
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tot_reg <= tot_next;
        if (cmd.accept)
        begin
            in_key_reg <= group_key;
            in_amt_reg <= amount;
            eos_reg    <= end_of_set;
        end
        if (cmd.compare)
        begin
            le_reg <= le_next;
            eq_reg <= eq_next;
        end
        if (cmd.dump_load)
        begin
            out_key_reg  <= key_reg[0];
            out_tot_reg  <= tot_reg[0];
            out_last_reg <= (count_reg == CNT_W'(1));
            out_ovf_reg  <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cmd.dump_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.eos        = eos_reg;
    assign status.last_entry = (count_reg == CNT_W'(1));
    assign status.out_free   = !out_valid_reg || out_ch.ready;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_key    = out_key_reg;
    assign out_ch.out_total  = out_tot_reg;
    assign out_ch.out_last   = out_last_reg;
    assign out_ch.overflowed = out_ovf_reg;

    // count stays within the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a dump never starts on an empty table
    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_load |-> count_reg != '0)
        else $error("dump load with empty table");

    // last entry of a dump clears count and overflow flag
    a_dump_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.dump_load && count_reg == CNT_W'(1)) |=> (count_reg == '0 && !ovf_reg))
        else $error("table not cleared after dump");

    // dropped key sets the sticky flag
    a_ovf_set: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && !hit && full) |=> ovf_reg)
        else $error("overflow flag not set on dropped key");

endmodule

`default_nettype wire

[hdl/sorted_group_sum_table.sv]
// Update: a record is latched on accept, compared in CMP and written into the table in UPD.
// Overlap: the next record may be accepted during the update of the previous one.
// Dump: the first result is registered in DUMP after the ending record's update, then one
//   entry per cycle while the sink is ready; the table array shift sets this rate.
// Reset: rst_n clears entry count, overflow flag, output valid and controller state;
//   no clearing pass, table contents are don't-care at and above the count.
// ---------------------------------------------------------------------------
// sorted_group_sum_table
// Keeps distinct group keys in ascending order with a saturating sum each,
// and emits the whole table in key order when a request marks end of set.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_group_sum_table
    import sgs_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    sgs_in_if.sink    in_ch,
    sgs_out_if.source out_ch
);

    sgs_cmd_t    cmd;
    sgs_status_t status;
    logic        in_ready;

    // Controller:
    //   IDLE  - waits for a request, latches it
    //   CMP   - every entry compares its key against the request key (<= and ==)
    //   UPD   - insert by shifting the upper part of the array, accumulate in the matching
    //           entry, or set overflow when full; a new request may be taken in the same cycle
    //   DUMP  - head entry to output register, array shifts down, until empty
    sgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign in_ch.ready = in_ready;

    // Datapath: register array of keys and totals, compare flags, output register.
    sgs_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .group_key  (in_ch.group_key),
        .amount     (in_ch.amount),
        .end_of_set (in_ch.end_of_set),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

[sim/sorted_group_sum_table_test.sv]
// ---------------------------------------------------------------------------
// sorted_group_sum_table_test
// Self-checking bench for the sorted group sum table. Records go in over the
// input channel, and a scoreboard keeps its own ordered key/sum table to work
// out every dump entry. It compares each result with the oldest pending one.
// It covers the field extremes, missing amounts, a table overflow under long
// output back-pressure, and random record sets.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_group_sum_table_test
    import sgs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = 32;
    localparam int HOLD_CYC   = 400;   // long output stall, forces input back-pressure
    localparam int RAND_ITEMS = 130;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TOT_W-1:0] total;
        logic             last;
        logic             ovf;
    } table_entry_t;

    // Ordered key/sum table kept beside the block, plus the pending dump entries.
    class group_sum_board;
        logic [KEY_W-1:0] keys   [CAPACITY];
        logic [TOT_W-1:0] totals [CAPACITY];
        int               count;
        bit               ovf;
        table_entry_t     dump_q[$];
        int               mismatches;

        function void note_record(logic [KEY_W-1:0] key, logic [AMT_W-1:0] amount,
                                  logic eos);
            int           pos;
            int           slot;
            logic [TOT_W:0] sum;
            table_entry_t ent;
            pos  = 0;
            slot = -1;
            // count of stored keys <= key
            while (pos < count && keys[pos] <= key)
                pos++;
            if (pos > 0 && keys[pos-1] == key)
                slot = pos - 1;
            else if (count >= CAPACITY)
                ovf = 1'b1;                 // new key dropped, amount ignored
            else
            begin
                for (int m = count; m > pos; m--)
                begin
                    keys[m]   = keys[m-1];
                    totals[m] = totals[m-1];
                end
                keys[pos]   = key;
                totals[pos] = '0;
                count++;
                slot = pos;
            end
            // negative amount marks a missing value: key entered, nothing added
            if (slot >= 0 && !amount[AMT_W-1])
            begin
                sum = {1'b0, totals[slot]} + (TOT_W+1)'(amount);
                totals[slot] = sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
            end
            if (eos)
            begin
                for (int k = 0; k < count; k++)
                begin
                    ent.key   = keys[k];
                    ent.total = totals[k];
                    ent.last  = (k == count - 1);
                    ent.ovf   = ovf;
                    dump_q    = {dump_q, ent};
                end
                count = 0;
                ovf   = 1'b0;
            end
        endfunction

        function void check_entry(table_entry_t got);
            table_entry_t want;
            if (dump_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: key %h total %h last %b ovf %b",
                             got.key, got.total, got.last, got.ovf);
                return;
            end
            want = dump_q.pop_front();
            if (got.key !== want.key || got.total !== want.total ||
                got.last !== want.last || got.ovf !== want.ovf)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp/got: key %h/%h total %h/%h last %b/%b ovf %b/%b",
                             want.key, got.key, want.total, got.total,
                             want.last, got.last, want.ovf, got.ovf);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_gaps;
    logic out_gaps;
    int   hold_ticket;

    sgs_in_if  in_ch();
    sgs_out_if out_ch();

    group_sum_board board = new;

    sorted_group_sum_table #(.CAPACITY(CAPACITY)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(16_000_000);
        $display("sorted_group_sum_table verification failed");
        $finish;
    end

    function automatic logic [AMT_W-1:0] pick_amount();
        case ($urandom_range(0, 3))
            0:       return {1'b1, 31'($urandom)};         // missing value
            1:       return 32'($urandom_range(0, 100));
            2:       return {1'b0, 31'($urandom)};
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // Offer one request and hold it until the block takes it; called at a posedge.
    task automatic send_record(logic [KEY_W-1:0] key, logic [AMT_W-1:0] amount,
                               logic eos);
        while (in_gaps && $urandom_range(0, 99) < 6)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.group_key  <= key;
        in_ch.amount     <= amount;
        in_ch.end_of_set <= eos;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_record(key, amount, eos);
    endtask

    // Result side: check on each handshake, then pick ready for the next cycle.
    initial
    begin
        int           hold_left;
        int           holds_taken;
        table_entry_t got;
        hold_left    = 0;
        holds_taken  = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.key   = out_ch.out_key;
                got.total = out_ch.out_total;
                got.last  = out_ch.out_last;
                got.ovf   = out_ch.overflowed;
                board.check_entry(got);
            end
            if (hold_ticket != holds_taken)
            begin
                holds_taken = hold_ticket;
                hold_left   = HOLD_CYC;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= !out_gaps || ($urandom_range(0, 99) >= 6);
        end
    end

    initial
    begin
        int               rand_items;
        int               n;
        int               psz;
        logic [KEY_W-1:0] pool [8];
        logic             wide;

        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.group_key  = '0;
        in_ch.amount     = '0;
        in_ch.end_of_set = 1'b0;
        in_gaps          = 1'b1;
        out_gaps         = 1'b1;
        hold_ticket      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lowest key, zero amount, ending request alone
        send_record('0, '0, 1'b1);
        // key/amount extremes, missing marks, repeat key, ending on a new key
        send_record(31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_record('0, 32'hFFFF_FFFF, 1'b0);
        send_record(31'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_record(31'd5, 32'd1, 1'b0);
        send_record(31'd5, 32'd2, 1'b0);
        send_record(31'd3, 32'h7FFF_FFFF, 1'b1);
        // ending request with a missing amount on a fresh key
        send_record(31'd9, 32'hFFFF_FFFF, 1'b1);

        // table overflow: fill out of order, drop a new key, add to a stored one,
        // then end on another dropped key while the result side stalls
        for (int i = 0; i < CAPACITY; i++)
            send_record(31'(i * 32'h1DE7_3B51), pick_amount(), 1'b0);
        send_record(31'h1234_5678, 32'd77, 1'b0);
        send_record(31'(32'h1DE7_3B51), 32'd1000, 1'b0);
        hold_ticket <= hold_ticket + 1;
        send_record(31'h7FFF_FFFE, 32'd5, 1'b1);

        // random record sets; the sender keeps going into the stalled dump
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            in_gaps  <= !(rand_items >= 60 && rand_items < 110);
            out_gaps <= !(rand_items >= 60 && rand_items < 110);
            case ($urandom_range(0, 9))
                0:
                begin
                    // more distinct keys than the table holds
                    n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
                    for (int j = 0; j < n; j++)
                        send_record(31'($urandom), pick_amount(), j == n - 1);
                end
                1:
                begin
                    n = 1;
                    send_record(31'($urandom), 32'($urandom), 1'b1);
                end
                default:
                begin
                    // small pool of keys so sums build up and order gets tested
                    psz  = $urandom_range(1, 8);
                    wide = 1'($urandom_range(0, 1));
                    for (int p = 0; p < psz; p++)
                        pool[p] = wide ? 31'($urandom) : 31'($urandom_range(0, 31));
                    n = $urandom_range(1, 12);
                    for (int j = 0; j < n; j++)
                        send_record(pool[$urandom_range(0, psz - 1)], pick_amount(),
                                    j == n - 1);
                end
            endcase
            rand_items += n;
        end
        in_ch.valid <= 1'b0;

        while (board.dump_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.mismatches == 0)
            $display("sorted_group_sum_table verification clean");
        else
            $display("sorted_group_sum_table verification failed");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hdl/sgs_pkg.sv
hdl/sgs_in_if.sv
hdl/sgs_out_if.sv
hdl/sgs_ctrl.sv
hdl/sgs_datapath.sv
hdl/sorted_group_sum_table.sv
sim/sorted_group_sum_table_test.sv
